>>> rtl/sfdsp_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sfdsp_pkg: shared constants and types of the serial frame servo PWM block
// Frame bytes, parser phases, register indexes, reset values and the packed
// state words that live in the state memories.
// ---------------------------------------------------------------------------
package sfdsp_pkg;

    // number of servo positions per axis
    localparam int STEPS = 180;

    localparam logic [7:0] STEP_MAX = 8'(STEPS - 1);
    localparam logic [8:0] STEPS_W  = 9'(STEPS);

    // reciprocal of STEPS for the step size, estimate is low by at most one
    localparam int          RECIP_SHIFT = 24;
    localparam logic [24:0] RECIP       = 25'((64'd1 << RECIP_SHIFT) / STEPS);

    // frame delimiters
    localparam logic [7:0] START_BYTE = 8'h02;
    localparam logic [7:0] END_BYTE   = 8'h18;

    // input word kinds
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // parser phases
    localparam logic [1:0] PH_WAIT = 2'd0;
    localparam logic [1:0] PH_X    = 2'd1;
    localparam logic [1:0] PH_Y    = 2'd2;
    localparam logic [1:0] PH_END  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_PERIOD = 2'd0;
    localparam logic [1:0] REG_MIN    = 2'd1;
    localparam logic [1:0] REG_MAX    = 2'd2;

    localparam logic [15:0] RST_PERIOD = 16'd22000;
    localparam logic [15:0] RST_MIN    = 16'd720;
    localparam logic [15:0] RST_MAX    = 16'd2600;

    // parser and timer state word
    typedef struct packed {
        logic [1:0]  phase;
        logic [7:0]  x_step;
        logic [7:0]  y_step;
        logic [15:0] tick;
    } t_front;

    // duty state word
    typedef struct packed {
        logic [15:0] duty_a;
        logic [15:0] duty_b;
    } t_duty;

endpackage
`default_nettype wire

>>> rtl/sfdsp_in_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sfdsp_in_if: input channel of the servo PWM block
// One word is either a received serial byte or one timer tick.
// ---------------------------------------------------------------------------
interface sfdsp_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] rx_byte;

    modport source (output valid, output operation, output rx_byte, input ready);
    modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface
`default_nettype wire

>>> rtl/sfdsp_out_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sfdsp_out_if: result channel of the servo PWM block
// PWM levels, current duties and the frame commit flag, one word per input.
// ---------------------------------------------------------------------------
interface sfdsp_out_if;
    logic        valid;
    logic        ready;
    logic        pwm_a;
    logic        pwm_b;
    logic [15:0] duty_a_now;
    logic [15:0] duty_b_now;
    logic        frame_committed;

    modport source (output valid, output pwm_a, output pwm_b, output duty_a_now,
                    output duty_b_now, output frame_committed, input ready);
    modport sink   (input valid, input pwm_a, input pwm_b, input duty_a_now,
                    input duty_b_now, input frame_committed, output ready);
endinterface
`default_nettype wire

>>> rtl/sfdsp_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sfdsp_ram: generic single-clock RAM
// One write port, one read port, read data registered (old data returned
// when reading the entry being written).
// ---------------------------------------------------------------------------
module sfdsp_ram #(
    parameter  int WIDTH  = 8,
    parameter  int DEPTH  = 2,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> rtl/serial_frame_dual_servo_pwm.sv
`default_nettype none
// ---------------------------------------------------------------------------
// serial_frame_dual_servo_pwm: two servo PWM outputs set by serial frames
//
// Input channel i_in carries one word per received serial byte or per timer
// tick. Frames are 0x02, X step, Y step, 0x18; a good frame sets the duty of
// output A from X and of output B from Y. Ticks advance the PWM counter.
// Every input word gives one result word on o_out: both PWM levels, both
// current duties and a flag for a committed frame.
// Throughput is one word per cycle while o_out does not stall. A result
// reaches the output register through the stage registers in order: the parser
// read-modify-write on the front state memory happens at the accepting edge,
// then the stages hold the step size reciprocal multiply, its correction and
// the step multiply; the duty read-modify-write goes into the output register.
// The configuration port (i_cfg_we, i_cfg_idx, i_cfg_data) must be written
// only while no word is in flight; the block does not enforce this. Reset
// restores the register defaults, puts the parser in the wait phase and
// reads duties and counter as zero. When o_out stalls, the pipeline fills its
// empty stages and then holds; i_in.ready drops only once every stage is occupied.
// ---------------------------------------------------------------------------
module serial_frame_dual_servo_pwm
    import sfdsp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    sfdsp_in_if.sink         i_in,
    sfdsp_out_if.source      o_out
);

    // configuration registers
    logic [15:0] r_period;
    logic [15:0] r_min;
    logic [15:0] r_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= RST_PERIOD;
            r_min    <= RST_MIN;
            r_max    <= RST_MAX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PERIOD: r_period <= i_cfg_data;
                REG_MIN:    r_min    <= i_cfg_data;
                REG_MAX:    r_max    <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // pipeline handshake
    logic r_v1, r_v2, r_v3, r_v4, r_out_vld;
    logic mv1, mv2, mv3, mv_out, acc_in;

    assign mv_out     = r_v4 && (!r_out_vld || o_out.ready);
    assign mv3        = r_v3 && (!r_v4 || mv_out);
    assign mv2        = r_v2 && (!r_v3 || mv3);
    assign mv1        = r_v1 && (!r_v2 || mv2);
    assign i_in.ready = !r_v1 || mv1;
    assign acc_in     = i_in.valid && i_in.ready;

    // -----------------------------------------------------------------------
    // front state: parser phase, steps and tick counter in memory
    // -----------------------------------------------------------------------
    t_front front_q;
    t_front front_cur;
    t_front n_front;
    t_front r_front_fwd;
    logic   r_front_fwd_vld;
    logic   r_front_init;
    logic   commit;
    logic [15:0] top;

    sfdsp_ram #(
        .WIDTH ($bits(t_front)),
        .DEPTH (2)
    ) u_front_ram (
        .i_clk   (i_clk),
        .i_we    (acc_in),
        .i_waddr (1'b0),
        .i_wdata (n_front),
        .i_raddr (1'b0),
        .o_rdata (front_q)
    );

    // last write forwarded; an entry never written reads as reset state
    assign front_cur = r_front_fwd_vld ? r_front_fwd : (r_front_init ? front_q : '0);
    assign top       = r_period - 16'd1;

    always_comb begin
        n_front = front_cur;
        commit  = 1'b0;
        if (i_in.operation == OP_TICK) begin
            if (front_cur.tick >= top) begin
                n_front.tick = '0;
            end else begin
                n_front.tick = front_cur.tick + 16'd1;
            end
        end else begin
            unique case (front_cur.phase)
                PH_WAIT: begin
                    if (i_in.rx_byte == START_BYTE) begin
                        n_front.phase = PH_X;
                    end
                end
                PH_X: begin
                    n_front.x_step = ({1'b0, i_in.rx_byte} >= STEPS_W) ? STEP_MAX
                                                                       : i_in.rx_byte;
                    n_front.phase  = PH_Y;
                end
                PH_Y: begin
                    n_front.y_step = ({1'b0, i_in.rx_byte} >= STEPS_W) ? STEP_MAX
                                                                       : i_in.rx_byte;
                    n_front.phase  = PH_END;
                end
                default: begin
                    commit        = (i_in.rx_byte == END_BYTE);
                    n_front.phase = PH_WAIT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_fwd_vld <= 1'b0;
            r_front_init    <= 1'b0;
        end else begin
            r_front_fwd_vld <= acc_in;
            if (acc_in) begin
                r_front_init <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_front_fwd <= n_front;
        end
    end

    // -----------------------------------------------------------------------
    // stage 1: span between min and max duty
    // -----------------------------------------------------------------------
    logic        r_commit1, r_commit2, r_commit3, r_commit4;
    logic [15:0] r_tick1, r_tick2, r_tick3, r_tick4;
    logic [8:0]  r_inc_a1, r_inc_a2, r_inc_a3;
    logic [8:0]  r_inc_b1, r_inc_b2, r_inc_b3;
    logic [15:0] r_diff1, r_diff2;
    logic [15:0] r_qest2;
    logic [15:0] r_size3;
    logic [15:0] r_pa4, r_pb4;

    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_commit1 <= commit;
            r_tick1   <= n_front.tick;
            r_inc_a1  <= {1'b0, n_front.x_step} + 9'd1;
            r_inc_b1  <= {1'b0, n_front.y_step} + 9'd1;
            r_diff1   <= (r_max >= r_min) ? (r_max - r_min) : 16'd0;
        end
    end

    // stage 2: quotient estimate through the reciprocal
    logic [40:0] est_prod;
    assign est_prod = 41'(r_diff1) * 41'(RECIP);

    always_ff @(posedge i_clk) begin
        if (mv1) begin
            r_commit2 <= r_commit1;
            r_tick2   <= r_tick1;
            r_inc_a2  <= r_inc_a1;
            r_inc_b2  <= r_inc_b1;
            r_diff2   <= r_diff1;
            r_qest2   <= est_prod[RECIP_SHIFT +: 16];
        end
    end

    // stage 3: correct the estimate by one where the remainder is too big
    logic [24:0] qd_prod;
    logic [15:0] rem;
    assign qd_prod = 25'(r_qest2) * 25'(STEPS_W);
    assign rem     = r_diff2 - qd_prod[15:0];

    always_ff @(posedge i_clk) begin
        if (mv2) begin
            r_commit3 <= r_commit2;
            r_tick3   <= r_tick2;
            r_inc_a3  <= r_inc_a2;
            r_inc_b3  <= r_inc_b2;
            r_size3   <= (rem >= 16'(STEPS_W)) ? (r_qest2 + 16'd1) : r_qest2;
        end
    end

    // stage 4: step offsets, only the low 16 bits survive
    logic [24:0] pa_prod, pb_prod;
    assign pa_prod = 25'(r_inc_a3) * 25'(r_size3);
    assign pb_prod = 25'(r_inc_b3) * 25'(r_size3);

    always_ff @(posedge i_clk) begin
        if (mv3) begin
            r_commit4 <= r_commit3;
            r_tick4   <= r_tick3;
            r_pa4     <= pa_prod[15:0];
            r_pb4     <= pb_prod[15:0];
        end
    end

    // -----------------------------------------------------------------------
    // duty state in memory, updated in word order into the output register
    // -----------------------------------------------------------------------
    t_duty duty_q;
    t_duty duty_cur;
    t_duty n_duty;
    t_duty r_duty_fwd;
    logic  r_duty_fwd_vld;
    logic  r_duty_init;

    sfdsp_ram #(
        .WIDTH ($bits(t_duty)),
        .DEPTH (2)
    ) u_duty_ram (
        .i_clk   (i_clk),
        .i_we    (mv_out),
        .i_waddr (1'b0),
        .i_wdata (n_duty),
        .i_raddr (1'b0),
        .o_rdata (duty_q)
    );

    assign duty_cur = r_duty_fwd_vld ? r_duty_fwd : (r_duty_init ? duty_q : '0);

    always_comb begin
        n_duty = duty_cur;
        if (r_commit4) begin
            n_duty.duty_a = r_min + r_pa4;
            n_duty.duty_b = r_min + r_pb4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty_fwd_vld <= 1'b0;
            r_duty_init    <= 1'b0;
        end else begin
            r_duty_fwd_vld <= mv_out;
            if (mv_out) begin
                r_duty_init <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mv_out) begin
            r_duty_fwd <= n_duty;
        end
    end

    // output register
    logic        r_pwm_a, r_pwm_b, r_commit_out;
    logic [15:0] r_duty_a_out, r_duty_b_out;

    always_ff @(posedge i_clk) begin
        if (mv_out) begin
            r_pwm_a      <= (r_tick4 < n_duty.duty_a);
            r_pwm_b      <= (r_tick4 < n_duty.duty_b);
            r_duty_a_out <= n_duty.duty_a;
            r_duty_b_out <= n_duty.duty_b;
            r_commit_out <= r_commit4;
        end
    end

    // stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_v4      <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (acc_in) begin
                r_v1 <= 1'b1;
            end else if (mv1) begin
                r_v1 <= 1'b0;
            end
            if (mv1) begin
                r_v2 <= 1'b1;
            end else if (mv2) begin
                r_v2 <= 1'b0;
            end
            if (mv2) begin
                r_v3 <= 1'b1;
            end else if (mv3) begin
                r_v3 <= 1'b0;
            end
            if (mv3) begin
                r_v4 <= 1'b1;
            end else if (mv_out) begin
                r_v4 <= 1'b0;
            end
            if (mv_out) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out.valid           = r_out_vld;
    assign o_out.pwm_a           = r_pwm_a;
    assign o_out.pwm_b           = r_pwm_b;
    assign o_out.duty_a_now      = r_duty_a_out;
    assign o_out.duty_b_now      = r_duty_b_out;
    assign o_out.frame_committed = r_commit_out;

endmodule
`default_nettype wire
